// ===== rtl/core/mcem_pkg.sv =====
package mcem_pkg;

  // field widths
  localparam int unsigned STATUS_W = 8;
  localparam int unsigned DATA_W   = 7;
  localparam int unsigned WORD14_W = 14;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned KIND_W   = 3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_BASE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_NOTE_OFF  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INSTRUMENT_COUNT = 2'd2;

  // configuration reset values
  localparam logic [DATA_W-1:0]  NOTE_BASE_RST        = 7'd36;
  localparam logic               IGNORE_NOTE_OFF_RST  = 1'b1;
  localparam logic [COUNT_W-1:0] INSTRUMENT_COUNT_RST = 8'd0;

  // state reset values
  localparam logic [WORD14_W-1:0] BANK_RST   = 14'h0000;
  localparam logic [WORD14_W-1:0] VOLUME_RST = 14'h3FFF;

  // status byte decode
  localparam logic [STATUS_W-1:0] ST_SYS_RESET = 8'hFF;
  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_CONTROL  = 4'hB;
  localparam logic [3:0] ST_PROGRAM  = 4'hC;

  // controller numbers
  localparam logic [DATA_W-1:0] CTL_BANK_COARSE = 7'd0;
  localparam logic [DATA_W-1:0] CTL_VOL_COARSE  = 7'd7;
  localparam logic [DATA_W-1:0] CTL_BANK_FINE   = 7'd32;
  localparam logic [DATA_W-1:0] CTL_VOL_FINE    = 7'd39;
  localparam logic [DATA_W-1:0] CTL_SOUND_OFF   = 7'd120;
  localparam logic [DATA_W-1:0] CTL_NOTES_OFF   = 7'd123;

  // event kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_NOTE_ON  = 3'd0,
    KIND_NOTE_OFF = 3'd1,
    KIND_VOLUME   = 3'd2,
    KIND_ALL_OFF  = 3'd3,
    KIND_PATCH    = 3'd4
  } kind_t;

  typedef struct packed {
    logic [DATA_W-1:0]  note_base;
    logic               ignore_note_off;
    logic [COUNT_W-1:0] instrument_count;
  } cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status_byte;
    logic [DATA_W-1:0]   data_one;
    logic [DATA_W-1:0]   data_two;
  } msg_t;

  typedef struct packed {
    logic                event_valid;
    logic [KIND_W-1:0]   event_kind;
    logic [DATA_W-1:0]   instrument_index;
    logic [DATA_W-1:0]   velocity_level;
    logic [WORD14_W-1:0] volume_level;
    logic [WORD14_W-1:0] bank_number;
    logic [DATA_W-1:0]   program_number;
  } result_t;

endpackage

// ===== rtl/core/mcem_in_stage.sv =====
module mcem_in_stage import mcem_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  msg_t in_msg,
  input  logic advance,
  output logic msg_valid,
  output msg_t msg
);

  logic valid_r, valid_nxt;
  msg_t msg_r;
  logic take;

  // a held message that cannot move on blocks the input
  assign in_stall = valid_r && !advance;
  assign take     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (take) begin
      msg_r <= in_msg;
    end
  end

  assign msg_valid = valid_r;
  assign msg       = msg_r;

endmodule

// ===== rtl/core/mcem_decode.sv =====
module mcem_decode import mcem_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    advance,
  input  cfg_t    cfg,
  input  msg_t    msg,
  output result_t res
);

  logic [WORD14_W-1:0] bank_r, bank_nxt;
  logic [WORD14_W-1:0] vol_r, vol_nxt;

  logic [3:0]         nibble;
  logic               is_sys_reset;
  logic               note_on;
  logic               note_release;
  logic [COUNT_W-1:0] idx_wide;
  logic               note_ok;

  assign nibble       = msg.status_byte[STATUS_W-1:4];
  assign is_sys_reset = (msg.status_byte == ST_SYS_RESET);
  assign note_on      = (nibble == ST_NOTE_ON) && (msg.data_two != '0);
  assign note_release = (nibble == ST_NOTE_OFF) ||
                        ((nibble == ST_NOTE_ON) && (msg.data_two == '0));

  // note to instrument mapping
  assign idx_wide = {1'b0, msg.data_one} - {1'b0, cfg.note_base};
  assign note_ok  = (msg.data_one >= cfg.note_base) &&
                    (cfg.instrument_count != '0) &&
                    (idx_wide < cfg.instrument_count);

  always_comb begin
    res      = '0;
    bank_nxt = bank_r;
    vol_nxt  = vol_r;
    if (is_sys_reset) begin
      res.event_valid = 1'b1;
      res.event_kind  = KIND_ALL_OFF;
    end else if (note_on) begin
      if (note_ok) begin
        res.event_valid      = 1'b1;
        res.event_kind       = KIND_NOTE_ON;
        res.instrument_index = idx_wide[DATA_W-1:0];
        res.velocity_level   = msg.data_two;
      end
    end else if (note_release) begin
      if (!cfg.ignore_note_off && note_ok) begin
        res.event_valid      = 1'b1;
        res.event_kind       = KIND_NOTE_OFF;
        res.instrument_index = idx_wide[DATA_W-1:0];
      end
    end else if (nibble == ST_CONTROL) begin
      // controller dispatch
      unique case (msg.data_one)
        CTL_BANK_COARSE: bank_nxt = {msg.data_two, bank_r[DATA_W-1:0]};
        CTL_BANK_FINE:   bank_nxt = {bank_r[WORD14_W-1:DATA_W], msg.data_two};
        CTL_VOL_COARSE: begin
          vol_nxt          = {msg.data_two, vol_r[DATA_W-1:0]};
          res.event_valid  = 1'b1;
          res.event_kind   = KIND_VOLUME;
          res.volume_level = vol_nxt;
        end
        CTL_VOL_FINE: begin
          vol_nxt          = {vol_r[WORD14_W-1:DATA_W], msg.data_two};
          res.event_valid  = 1'b1;
          res.event_kind   = KIND_VOLUME;
          res.volume_level = vol_nxt;
        end
        CTL_SOUND_OFF, CTL_NOTES_OFF: begin
          res.event_valid = 1'b1;
          res.event_kind  = KIND_ALL_OFF;
        end
        default: ;
      endcase
    end else if (nibble == ST_PROGRAM) begin
      res.event_valid    = 1'b1;
      res.event_kind     = KIND_PATCH;
      res.bank_number    = bank_r;
      res.program_number = msg.data_one;
    end
  end

  // bank and volume update only when the message moves to the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= BANK_RST;
      vol_r  <= VOLUME_RST;
    end else if (advance) begin
      bank_r <= bank_nxt;
      vol_r  <= vol_nxt;
    end
  end

endmodule

// ===== rtl/core/mcem_out_stage.sv =====
module mcem_out_stage import mcem_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    msg_valid,
  input  result_t res,
  output logic    advance,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  // move on when the result register is empty or being drained
  assign advance = msg_valid && (!valid_r || !out_stall);

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== rtl/core/midi_channel_event_mapper_top.sv =====
// path: a transferred message waits in the input register and is decoded
// combinationally; its result enters the result register when that is free or draining
// throughput: one message per cycle while out_stall is low; input and result
// registers form a two-entry pipeline that takes one more message while a result waits
// reset (rst_n low, synchronous): pipeline empty, note base 36, note-offs ignored,
// no instruments, bank 0, volume full scale
module midi_channel_event_mapper_top import mcem_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COUNT_W-1:0]    cfg_data,
  // message channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [STATUS_W-1:0]   in_status_byte,
  input  logic [DATA_W-1:0]     in_data_one,
  input  logic [DATA_W-1:0]     in_data_two,
  // event channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_event_valid,
  output logic [KIND_W-1:0]     out_event_kind,
  output logic [DATA_W-1:0]     out_instrument_index,
  output logic [DATA_W-1:0]     out_velocity_level,
  output logic [WORD14_W-1:0]   out_volume_level,
  output logic [WORD14_W-1:0]   out_bank_number,
  output logic [DATA_W-1:0]     out_program_number
);

  cfg_t    cfg_r;
  msg_t    in_msg;
  msg_t    msg;
  logic    msg_valid;
  logic    advance;
  result_t res;
  result_t out_res;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.note_base        <= NOTE_BASE_RST;
      cfg_r.ignore_note_off  <= IGNORE_NOTE_OFF_RST;
      cfg_r.instrument_count <= INSTRUMENT_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NOTE_BASE:        cfg_r.note_base        <= cfg_data[DATA_W-1:0];
        REG_IGNORE_NOTE_OFF:  cfg_r.ignore_note_off  <= cfg_data[0];
        REG_INSTRUMENT_COUNT: cfg_r.instrument_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_msg.status_byte = in_status_byte;
  assign in_msg.data_one    = in_data_one;
  assign in_msg.data_two    = in_data_two;

  mcem_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_msg    (in_msg),
    .advance   (advance),
    .msg_valid (msg_valid),
    .msg       (msg)
  );

  mcem_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .cfg     (cfg_r),
    .msg     (msg),
    .res     (res)
  );

  mcem_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .msg_valid (msg_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_event_valid      = out_res.event_valid;
  assign out_event_kind       = out_res.event_kind;
  assign out_instrument_index = out_res.instrument_index;
  assign out_velocity_level   = out_res.velocity_level;
  assign out_volume_level     = out_res.volume_level;
  assign out_bank_number      = out_res.bank_number;
  assign out_program_number   = out_res.program_number;

  // an accepted message is always held in the input register next cycle
  a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> msg_valid)
    else $error("accepted message not captured");

  // a result without an event carries all-zero fields
  a_no_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_event_valid) |->
      (out_event_kind == '0 && out_instrument_index == '0 &&
       out_velocity_level == '0 && out_volume_level == '0 &&
       out_bank_number == '0 && out_program_number == '0))
    else $error("non-event result has non-zero fields");

  // note events only reference loaded instruments
  a_note_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_valid &&
     (out_event_kind == KIND_NOTE_ON || out_event_kind == KIND_NOTE_OFF)) |->
      ({1'b0, out_instrument_index} < cfg_r.instrument_count))
    else $error("note event beyond instrument count");

  // a note-on never reports zero velocity
  a_note_on_vel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_valid && out_event_kind == KIND_NOTE_ON) |->
      (out_velocity_level != '0))
    else $error("note-on with zero velocity");

endmodule

// ===== tb/midi_channel_event_mapper_top_test.sv =====
`timescale 1ns / 1ps
module midi_channel_event_mapper_top_test;
  import mcem_pkg::*;

  // status nibbles and controllers that the mapper does not act on
  localparam logic [3:0]        ST_AFTERTOUCH  = 4'hA;
  localparam logic [3:0]        ST_SYSTEM      = 4'hF;
  localparam logic [DATA_W-1:0] CTL_MODULATION = 7'd1;

  localparam int HOLD_OFF_CYCLES   = 60;
  localparam int ITEMS_PER_SETTING = 50;
  localparam int MAX_REPORTS       = 10;

  // block inputs, all known from time zero
  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 cfg_valid      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index      = '0;
  logic [COUNT_W-1:0]   cfg_data       = '0;
  logic                 in_valid       = 1'b0;
  logic [STATUS_W-1:0]  in_status_byte = '0;
  logic [DATA_W-1:0]    in_data_one    = '0;
  logic [DATA_W-1:0]    in_data_two    = '0;
  logic                 out_stall      = 1'b0;

  // block outputs
  logic                cfg_ready;
  logic                in_stall;
  logic                out_valid;
  logic                out_event_valid;
  logic [KIND_W-1:0]   out_event_kind;
  logic [DATA_W-1:0]   out_instrument_index;
  logic [DATA_W-1:0]   out_velocity_level;
  logic [WORD14_W-1:0] out_volume_level;
  logic [WORD14_W-1:0] out_bank_number;
  logic [DATA_W-1:0]   out_program_number;

  // mapper state as the block should hold it
  logic [DATA_W-1:0]   note_base_cfg  = NOTE_BASE_RST;
  logic                ignore_off_cfg = IGNORE_NOTE_OFF_RST;
  logic [COUNT_W-1:0]  inst_count_cfg = INSTRUMENT_COUNT_RST;
  logic [WORD14_W-1:0] bank_reg       = BANK_RST;
  logic [WORD14_W-1:0] volume_reg     = VOLUME_RST;

  result_t pending_events[$];
  result_t got_event;
  result_t want_event;

  int send_idle_pct    = 0;
  int recv_idle_pct    = 0;
  logic stall_hold     = 1'b0;
  event hold_off_ev;

  int error_count      = 0;
  int msgs_sent        = 0;
  int events_checked   = 0;
  int events_fired     = 0;
  int settings_applied = 0;

  midi_channel_event_mapper_top DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_status_byte       (in_status_byte),
    .in_data_one          (in_data_one),
    .in_data_two          (in_data_two),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_event_valid      (out_event_valid),
    .out_event_kind       (out_event_kind),
    .out_instrument_index (out_instrument_index),
    .out_velocity_level   (out_velocity_level),
    .out_volume_level     (out_volume_level),
    .out_bank_number      (out_bank_number),
    .out_program_number   (out_program_number)
  );

  // clock, 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // expected event for one message; updates the bank and volume copies
  function automatic result_t decode_message(input msg_t m);
    result_t            r;
    logic [3:0]         kind_nib;
    logic [COUNT_W-1:0] offset;
    logic               hit;
    r        = '0;
    kind_nib = m.status_byte[7:4];
    offset   = {1'b0, m.data_one} - {1'b0, note_base_cfg};
    hit      = (m.data_one >= note_base_cfg) && (inst_count_cfg != 0) &&
               (offset < inst_count_cfg);
    if (m.status_byte == ST_SYS_RESET) begin
      r.event_valid = 1'b1;
      r.event_kind  = KIND_ALL_OFF;
    end else if (kind_nib == ST_NOTE_ON && m.data_two != 0) begin
      if (hit) begin
        r.event_valid      = 1'b1;
        r.event_kind       = KIND_NOTE_ON;
        r.instrument_index = offset[DATA_W-1:0];
        r.velocity_level   = m.data_two;
      end
    end else if (kind_nib == ST_NOTE_OFF || kind_nib == ST_NOTE_ON) begin
      // zero-velocity note-on lands here as well
      if (!ignore_off_cfg && hit) begin
        r.event_valid      = 1'b1;
        r.event_kind       = KIND_NOTE_OFF;
        r.instrument_index = offset[DATA_W-1:0];
      end
    end else if (kind_nib == ST_CONTROL) begin
      case (m.data_one)
        CTL_BANK_COARSE: bank_reg[13:7] = m.data_two;
        CTL_BANK_FINE:   bank_reg[6:0]  = m.data_two;
        CTL_VOL_COARSE, CTL_VOL_FINE: begin
          if (m.data_one == CTL_VOL_COARSE) volume_reg[13:7] = m.data_two;
          else volume_reg[6:0] = m.data_two;
          r.event_valid  = 1'b1;
          r.event_kind   = KIND_VOLUME;
          r.volume_level = volume_reg;
        end
        CTL_SOUND_OFF, CTL_NOTES_OFF: begin
          r.event_valid = 1'b1;
          r.event_kind  = KIND_ALL_OFF;
        end
        default: ;
      endcase
    end else if (kind_nib == ST_PROGRAM) begin
      r.event_valid    = 1'b1;
      r.event_kind     = KIND_PATCH;
      r.bank_number    = bank_reg;
      r.program_number = m.data_one;
    end
    return r;
  endfunction

  // mostly well-formed messages, notes clustered round the loaded range
  function automatic msg_t random_message();
    msg_t m;
    int   pick;
    int   note;
    pick = $urandom_range(99);
    note = int'(note_base_cfg) + int'($urandom_range(inst_count_cfg + 4)) - 2;
    m.data_one    = ($urandom_range(3) == 0) ? 7'($urandom) : 7'(note);
    m.data_two    = ($urandom_range(6) == 0) ? 7'd0 : 7'($urandom_range(127, 1));
    m.status_byte = {ST_NOTE_ON, 4'($urandom)};
    if (pick >= 30 && pick < 45) begin
      m.status_byte = {ST_NOTE_OFF, 4'($urandom)};
    end else if (pick >= 45 && pick < 65) begin
      m.status_byte = {ST_CONTROL, 4'($urandom)};
      m.data_two    = 7'($urandom);
      case ($urandom_range(7))
        0: m.data_one = CTL_BANK_COARSE;
        1: m.data_one = CTL_BANK_FINE;
        2: m.data_one = CTL_VOL_COARSE;
        3: m.data_one = CTL_VOL_FINE;
        4: m.data_one = CTL_SOUND_OFF;
        5: m.data_one = CTL_NOTES_OFF;
        default: m.data_one = 7'($urandom);
      endcase
    end else if (pick >= 65 && pick < 75) begin
      m.status_byte = {ST_PROGRAM, 4'($urandom)};
    end else if (pick >= 75 && pick < 80) begin
      m.status_byte = ST_SYS_RESET;
    end else if (pick >= 80) begin
      m.status_byte = 8'($urandom);
      m.data_two    = 7'($urandom);
    end
    return m;
  endfunction

  // one message transfer, with random idle cycles ahead of it
  task automatic send_msg(input msg_t m);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_status_byte <= m.status_byte;
    in_data_one    <= m.data_one;
    in_data_two    <= m.data_two;
    do @(posedge clk); while (in_stall);
    pending_events.push_back(decode_message(m));
    msgs_sent++;
  endtask

  // stop sending and let every expected event come out
  task automatic drain_events();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write all three registers while the block is idle
  task automatic apply_config(input logic [DATA_W-1:0] base, input logic ignore_off,
                              input logic [COUNT_W-1:0] count);
    logic [COUNT_W-1:0]   value [3];
    logic [CFG_IDX_W-1:0] index [3];
    drain_events();
    index[0] = REG_NOTE_BASE;        value[0] = {1'b0, base};
    index[1] = REG_IGNORE_NOTE_OFF;  value[1] = {7'd0, ignore_off};
    index[2] = REG_INSTRUMENT_COUNT; value[2] = count;
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= index[i];
      cfg_data  <= value[i];
      do @(posedge clk); while (!cfg_ready);
      case (index[i])
        REG_NOTE_BASE:        note_base_cfg  = value[i][DATA_W-1:0];
        REG_IGNORE_NOTE_OFF:  ignore_off_cfg = value[i][0];
        REG_INSTRUMENT_COUNT: inst_count_cfg = value[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  // reset settings: no sampler, so notes stay silent
  task automatic test_reset_defaults();
    send_idle_pct = 0;
    recv_idle_pct = 30;
    send_msg({ST_NOTE_ON, 4'h0, 7'd60, 7'd100});
    send_msg({ST_PROGRAM, 4'h1, 7'd5, 7'd0});
    send_msg({ST_SYS_RESET, 7'd0, 7'd0});
    send_msg({ST_CONTROL, 4'h2, CTL_VOL_COARSE, 7'd64});
    send_msg({ST_CONTROL, 4'h2, CTL_VOL_FINE, 7'd0});
  endtask

  // field extremes, the bank, all-off and unused controllers and the note mapping edges
  task automatic test_directed_cases();
    apply_config(7'd0, 1'b0, 8'd128);
    send_msg({ST_NOTE_ON, 4'hF, 7'd0, 7'd127});
    send_msg({ST_NOTE_ON, 4'h0, 7'd127, 7'd1});
    send_msg({ST_NOTE_ON, 4'h3, 7'd5, 7'd0});
    send_msg({ST_NOTE_OFF, 4'h7, 7'd127, 7'd99});
    send_msg({ST_CONTROL, 4'h0, CTL_BANK_COARSE, 7'd127});
    send_msg({ST_CONTROL, 4'hF, CTL_BANK_FINE, 7'd127});
    send_msg({ST_PROGRAM, 4'h0, 7'd127, 7'd127});
    send_msg({ST_CONTROL, 4'h5, CTL_SOUND_OFF, 7'd0});
    send_msg({ST_CONTROL, 4'h5, CTL_NOTES_OFF, 7'd127});
    send_msg({ST_CONTROL, 4'h5, CTL_MODULATION, 7'd64});
    send_msg({ST_SYSTEM, 4'h0, 7'd127, 7'd127});
    send_msg({8'h00, 7'd0, 7'd0});
    send_msg({8'h7F, 7'd85, 7'd42});
    send_msg({ST_AFTERTOUCH, 4'h5, 7'd60, 7'd60});
    // narrow window of loaded instruments
    apply_config(7'd100, 1'b1, 8'd10);
    send_msg({ST_NOTE_ON, 4'h0, 7'd99, 7'd50});
    send_msg({ST_NOTE_ON, 4'h0, 7'd109, 7'd50});
    send_msg({ST_NOTE_ON, 4'h0, 7'd110, 7'd50});
    send_msg({ST_NOTE_OFF, 4'h0, 7'd105, 7'd50});
    send_msg({ST_NOTE_ON, 4'h0, 7'd105, 7'd0});
    apply_config(7'd127, 1'b0, 8'd1);
    send_msg({ST_NOTE_ON, 4'hA, 7'd127, 7'd64});
    send_msg({ST_NOTE_OFF, 4'hA, 7'd127, 7'd0});
  endtask

  // random messages, settings changed every few dozen transfers
  task automatic test_random_traffic(input int n_items, input int send_pct,
                                     input int recv_pct);
    int sent;
    sent          = 0;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (sent < n_items) begin
      case ($urandom_range(5))
        0: apply_config(7'd0, 1'b0, 8'd128);
        1: apply_config(7'd127, 1'b1, 8'd1);
        2: apply_config(7'd127, 1'b0, 8'd128);
        3: apply_config(NOTE_BASE_RST, IGNORE_NOTE_OFF_RST, INSTRUMENT_COUNT_RST);
        default: apply_config(7'($urandom), 1'($urandom), 8'($urandom_range(128)));
      endcase
      for (int i = 0; i < ITEMS_PER_SETTING && sent < n_items; i++) begin
        send_msg(random_message());
        sent++;
      end
    end
  endtask

  // receiver holds off long enough for the pipeline to fill
  task automatic test_backpressure();
    apply_config(7'd20, 1'b0, 8'd64);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    -> hold_off_ev;
    for (int i = 0; i < 30; i++) send_msg(random_message());
    drain_events();
    for (int i = 0; i < 20; i++) send_msg(random_message());
  endtask

  // long receiver hold-off, counted here
  always begin
    @(hold_off_ev);
    stall_hold <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    stall_hold <= 1'b0;
  end

  // event checker and receiver stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_event = {out_event_valid, out_event_kind, out_instrument_index,
                   out_velocity_level, out_volume_level, out_bank_number,
                   out_program_number};
      events_checked++;
      if (got_event.event_valid) events_fired++;
      if (pending_events.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("event %0d arrived with nothing expected", events_checked);
      end else begin
        want_event = pending_events.pop_front();
        if (got_event !== want_event) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display({"event %0d mismatch: expected v%0d k%0d i%0d vel%0d vol%0d b%0d p%0d,",
                      " got v%0d k%0d i%0d vel%0d vol%0d b%0d p%0d"}, events_checked,
                     want_event.event_valid, want_event.event_kind,
                     want_event.instrument_index, want_event.velocity_level,
                     want_event.volume_level, want_event.bank_number,
                     want_event.program_number, got_event.event_valid,
                     got_event.event_kind, got_event.instrument_index,
                     got_event.velocity_level, got_event.volume_level,
                     got_event.bank_number, got_event.program_number);
        end
      end
    end
    out_stall <= stall_hold || ($urandom_range(99) < recv_idle_pct);
  end

  // test sequence
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed_cases();
    test_random_traffic(200, 27, 84);
    test_random_traffic(200, 84, 27);
    test_random_traffic(200, 0, 0);
    test_backpressure();
    drain_events();
    repeat (10) @(posedge clk);
    $display("covered %0d messages over %0d settings, %0d events checked (%0d active)",
             msgs_sent, settings_applied, events_checked, events_fired);
    $display("includes idle sender and receiver phases and a %0d-cycle receiver hold-off",
             HOLD_OFF_CYCLES);
    if (error_count == 0 && pending_events.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("timeout with %0d events still expected", pending_events.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
